// ===== src/pfsa_pkg.sv =====
// Shared types, constants and helper functions for the polyphase subband analyzer.
// Used by pfsa_ctrl, pfsa_dp and the top level; depends on nothing else.
package pfsa_pkg;

   localparam int BANDS         = 32;
   localparam int FILTER_LENGTH = 256;
   localparam int TAPS          = FILTER_LENGTH / BANDS;
   localparam int LOG_BANDS     = $clog2(BANDS);
   localparam int ADDR_W        = $clog2(FILTER_LENGTH);
   localparam int FILL_W        = $clog2(FILTER_LENGTH + 1);
   localparam int K_W           = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int B_W           = (LOG_BANDS > 1) ? LOG_BANDS - 1 : 1;
   localparam int S_W           = ($clog2(LOG_BANDS) > 0) ? $clog2(LOG_BANDS) : 1;
   localparam int ACC_W         = 35 + K_W;
   localparam int SQ_STEPS      = 32;
   localparam int SQ_CNT_W      = $clog2(SQ_STEPS);
   localparam int REM_W         = 36;

   localparam int FUNC_W        = 2;
   localparam int INDEX_W       = 8;
   localparam int COEF_W        = 18;
   localparam int SAMPLE_W      = 16;
   localparam int BAND_W        = 5;
   localparam int MAG_W         = 24;
   localparam int REQ_DATA_W    = 48;
   localparam int RSP_DATA_W    = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_COEF   = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MAC, ST_MAC_DRAIN,
      ST_BF_READ, ST_BF_M0, ST_BF_M1, ST_BF_M2, ST_BF_M3, ST_BF_ACC, ST_BF_WU, ST_BF_WV,
      ST_MG_READ, ST_MG_SQR, ST_MG_SQI, ST_MG_SUM, ST_SQRT, ST_MG_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_MAC, MUL_WR_XR, MUL_WI_XI, MUL_WR_XI, MUL_WI_XR, MUL_RE_RE, MUL_IM_IM
   } mul_sel_type;

   typedef enum logic [2:0] {
      TW_NONE, TW_TR_LOAD, TW_TR_SUB, TW_TI_LOAD, TW_TI_ADD
   } tw_op_type;

   typedef enum logic [1:0] {
      SQ_NONE, SQ_LOAD, SQ_ADD, SQ_STEP
   } sq_op_type;

   typedef struct packed {
      logic                  coef_we;
      logic                  hist_push;
      logic                  hist_clear;
      logic                  mac_issue;
      logic                  mac_last;
      logic [LOG_BANDS-1:0]  m;
      logic [K_W-1:0]        k;
      logic [S_W-1:0]        s;
      logic [B_W-1:0]        b;
      mul_sel_type           mul_sel;
      tw_op_type             tw_op;
      logic                  bf_read;
      logic                  mg_read;
      logic                  wr_u;
      logic                  wr_v;
      sq_op_type             sq_op;
      logic                  out_load;
   } cmd_type;

   typedef struct packed {
      logic mac_busy;
      logic rsp_busy;
   } status_type;

   localparam logic signed [16:0] QCOS [17] = '{
      17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
      17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
      17'sd12540, 17'sd9512, 17'sd6393, 17'sd3212, 17'sd0
   };

   function automatic logic signed [16:0] tw_cos(input logic [4:0] k);
      logic [4:0] mk;
      mk = 5'(6'd32 - {1'b0, k});
      if (k <= 5'd16) return QCOS[k];
      else return -QCOS[mk];
   endfunction

   function automatic logic signed [16:0] tw_sin(input logic [4:0] k);
      if (k <= 5'd16) return QCOS[5'd16 - k];
      else return QCOS[k - 5'd16];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

   function automatic logic [LOG_BANDS-1:0] bitrev(input logic [LOG_BANDS-1:0] v);
      logic [LOG_BANDS-1:0] r;
      for (int i = 0; i < LOG_BANDS; i++) r[i] = v[LOG_BANDS-1-i];
      return r;
   endfunction

endpackage

// ===== src/pfsa_ctrl.sv =====
// Sequencer for the subband analyzer: input decode, MAC, FFT and magnitude phases.
// Depends on pfsa_pkg; drives pfsa_dp through cmd_type and reads status_type.
module pfsa_ctrl
   import pfsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [FUNC_W-1:0]   req_func,
   output logic                req_tready,
   input  status_type          status,
   output cmd_type             cmd
);

   state_type               state_ff, state_in;
   logic [LOG_BANDS-1:0]    pos_ff, pos_in;
   logic [LOG_BANDS-1:0]    m_ff, m_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [S_W-1:0]          s_ff, s_in;
   logic [B_W-1:0]          b_ff, b_in;
   logic [SQ_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                    accept;
   logic                    block_done;
   logic                    m_end, k_end, b_end, s_end, cnt_end;

   assign accept     = req_tvalid && (state_ff == ST_IDLE);
   assign block_done = accept && (req_func == FUNC_SAMPLE) &&
                       (pos_ff == LOG_BANDS'(BANDS - 1));
   assign m_end      = (m_ff == LOG_BANDS'(BANDS - 1));
   assign k_end      = (k_ff == K_W'(TAPS - 1));
   assign b_end      = (b_ff == B_W'(BANDS / 2 - 1));
   assign s_end      = (s_ff == S_W'(LOG_BANDS - 1));
   assign cnt_end    = (cnt_ff == SQ_CNT_W'(SQ_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (block_done) state_in = ST_MAC;
         ST_MAC:       if (m_end && k_end) state_in = ST_MAC_DRAIN;
         ST_MAC_DRAIN: if (!status.mac_busy) state_in = ST_BF_READ;
         ST_BF_READ:   state_in = ST_BF_M0;
         ST_BF_M0:     state_in = ST_BF_M1;
         ST_BF_M1:     state_in = ST_BF_M2;
         ST_BF_M2:     state_in = ST_BF_M3;
         ST_BF_M3:     state_in = ST_BF_ACC;
         ST_BF_ACC:    state_in = ST_BF_WU;
         ST_BF_WU:     state_in = ST_BF_WV;
         ST_BF_WV:     state_in = (b_end && s_end) ? ST_MG_READ : ST_BF_READ;
         ST_MG_READ:   state_in = ST_MG_SQR;
         ST_MG_SQR:    state_in = ST_MG_SQI;
         ST_MG_SQI:    state_in = ST_MG_SUM;
         ST_MG_SUM:    state_in = ST_SQRT;
         ST_SQRT:      if (cnt_end) state_in = ST_MG_OUT;
         ST_MG_OUT: begin
            if (!status.rsp_busy) state_in = m_end ? ST_IDLE : ST_MG_READ;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.m          = m_ff;
      cmd.k          = k_ff;
      cmd.s          = s_ff;
      cmd.b          = b_ff;
      cmd.mul_sel    = MUL_MAC;
      cmd.tw_op      = TW_NONE;
      cmd.sq_op      = SQ_NONE;
      req_tready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.coef_we    = accept && (req_func == FUNC_COEF);
            cmd.hist_push  = accept && (req_func == FUNC_SAMPLE);
            cmd.hist_clear = accept && (req_func == FUNC_CLEAR);
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            cmd.mac_last  = k_end;
         end
         ST_MAC_DRAIN: cmd.mul_sel = MUL_MAC;
         ST_BF_READ:   cmd.bf_read = 1'b1;
         ST_BF_M0:     cmd.mul_sel = MUL_WR_XR;
         ST_BF_M1: begin
            cmd.mul_sel = MUL_WI_XI;
            cmd.tw_op   = TW_TR_LOAD;
         end
         ST_BF_M2: begin
            cmd.mul_sel = MUL_WR_XI;
            cmd.tw_op   = TW_TR_SUB;
         end
         ST_BF_M3: begin
            cmd.mul_sel = MUL_WI_XR;
            cmd.tw_op   = TW_TI_LOAD;
         end
         ST_BF_ACC:    cmd.tw_op = TW_TI_ADD;
         ST_BF_WU:     cmd.wr_u = 1'b1;
         ST_BF_WV:     cmd.wr_v = 1'b1;
         ST_MG_READ:   cmd.mg_read = 1'b1;
         ST_MG_SQR:    cmd.mul_sel = MUL_RE_RE;
         ST_MG_SQI: begin
            cmd.mul_sel = MUL_IM_IM;
            cmd.sq_op   = SQ_LOAD;
         end
         ST_MG_SUM:    cmd.sq_op = SQ_ADD;
         ST_SQRT:      cmd.sq_op = SQ_STEP;
         ST_MG_OUT:    cmd.out_load = !status.rsp_busy;
         default:      cmd.mul_sel = MUL_MAC;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      m_in   = m_ff;
      k_in   = k_ff;
      s_in   = s_ff;
      b_in   = b_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_CLEAR)) pos_in = '0;
            else if (accept && (req_func == FUNC_SAMPLE))
               pos_in = (pos_ff == LOG_BANDS'(BANDS - 1)) ? '0 : pos_ff + 1'b1;
            m_in = '0;
            k_in = '0;
         end
         ST_MAC: begin
            k_in = k_end ? '0 : k_ff + 1'b1;
            if (k_end) m_in = m_end ? '0 : m_ff + 1'b1;
            s_in = '0;
            b_in = '0;
         end
         ST_BF_WV: begin
            b_in = b_end ? '0 : b_ff + 1'b1;
            if (b_end) s_in = s_end ? '0 : s_ff + 1'b1;
            m_in = '0;
         end
         ST_MG_SUM: cnt_in = '0;
         ST_SQRT:   cnt_in = cnt_ff + 1'b1;
         ST_MG_OUT: begin
            if (!status.rsp_busy) m_in = m_end ? '0 : m_ff + 1'b1;
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         m_ff     <= '0;
         k_ff     <= '0;
         s_ff     <= '0;
         b_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         m_ff     <= m_in;
         k_ff     <= k_in;
         s_ff     <= s_in;
         b_ff     <= b_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== src/pfsa_dp.sv =====
// Datapath: coefficient and history memories, shared multiplier, FFT work memory,
// square root unit and result register. Depends on pfsa_pkg; driven by pfsa_ctrl.
module pfsa_dp
   import pfsa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [INDEX_W-1:0]      coef_index,
   input  logic signed [COEF_W-1:0]   coef_value,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BAND_W-1:0]       rsp_band,
   output logic [MAG_W-1:0]        rsp_magnitude,
   output logic                    rsp_last
);

   localparam int JW = LOG_BANDS + 5;

   logic signed [COEF_W-1:0]   coef_mem [FILTER_LENGTH];
   logic signed [SAMPLE_W-1:0] hist_mem [FILTER_LENGTH];
   logic [63:0]                fft_mem  [BANDS];

   logic signed [COEF_W-1:0]   coef_q;
   logic signed [SAMPLE_W-1:0] hist_q;
   logic [63:0]                rd_a_q, rd_b_q;

   logic [ADDR_W-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;

   logic [ADDR_W-1:0]          age, ci, hist_addr;
   logic [ADDR_W:0]            diff;
   logic                       age_zero;

   logic                       s1_valid_ff, s1_zero_ff, s1_last_ff, s1_first_ff;
   logic [LOG_BANDS-1:0]       s1_m_ff;
   logic                       s2_valid_ff, s2_last_ff, s2_first_ff;
   logic [LOG_BANDS-1:0]       s2_m_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in, acc_rnd;
   logic signed [31:0]         mac_sum;

   logic signed [31:0]         mul_a, mul_b;
   logic signed [63:0]         prod_ff;
   logic signed [16:0]         wr, wi;
   logic [LOG_BANDS-1:0]       b_ext, jv, u_addr, v_addr, rd_a_addr;
   logic [JW-1:0]              jw;
   logic [4:0]                 tw_k;
   logic signed [63:0]         tr_ff, ti_ff, trr, tir;
   logic signed [63:0]         ur, ui;
   logic signed [31:0]         xr, xi;

   logic [63:0]                sq_ff;
   logic [REM_W-1:0]           rem_ff, rem_t, trial;
   logic [31:0]                root_ff;
   logic                       ge;

   logic                       rsp_valid_ff;
   logic [BAND_W-1:0]          band_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic                       last_ff;

   // history ring: head holds the newest sample, fill counts samples since clear
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.hist_clear) begin
         fill_in = '0;
      end else if (cmd.hist_push) begin
         head_in = (head_ff == ADDR_W'(FILTER_LENGTH - 1)) ? '0 : head_ff + 1'b1;
         if (fill_ff != FILL_W'(FILTER_LENGTH)) fill_in = fill_ff + 1'b1;
      end
   end

   assign age       = ADDR_W'(BANDS - 1) - ADDR_W'(cmd.m) + (ADDR_W'(cmd.k) << LOG_BANDS);
   assign ci        = (ADDR_W'(cmd.k) << LOG_BANDS) | ADDR_W'(cmd.m);
   assign age_zero  = (FILL_W'(age) >= fill_ff);
   assign diff      = {1'b0, head_ff} - {1'b0, age};
   assign hist_addr = diff[ADDR_W] ? ADDR_W'(diff + (ADDR_W + 1)'(FILTER_LENGTH))
                                   : diff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.coef_we && (int'(coef_index) < FILTER_LENGTH))
         coef_mem[ADDR_W'(coef_index)] <= coef_value;
      if (cmd.hist_push) hist_mem[head_in] <= sample;
      if (cmd.mac_issue) begin
         coef_q <= coef_mem[ci];
         hist_q <= hist_mem[hist_addr];
      end
   end

   // butterfly addressing and twiddle index
   assign b_ext     = LOG_BANDS'(cmd.b);
   assign jv        = b_ext & ((LOG_BANDS'(1) << cmd.s) - 1'b1);
   assign u_addr    = ((b_ext >> cmd.s) << (cmd.s + 1'b1)) | jv;
   assign v_addr    = u_addr | (LOG_BANDS'(1) << cmd.s);
   assign jw        = (JW'(jv) << 5) >> cmd.s;
   assign tw_k      = jw[4:0];
   assign wr        = tw_cos(tw_k);
   assign wi        = -tw_sin(tw_k);
   assign rd_a_addr = cmd.mg_read ? cmd.m : u_addr;

   assign xr = rd_b_q[63:32];
   assign xi = rd_b_q[31:0];
   assign ur = {{32{rd_a_q[63]}}, rd_a_q[63:32]};
   assign ui = {{32{rd_a_q[31]}}, rd_a_q[31:0]};

   always_comb begin
      case (cmd.mul_sel)
         MUL_MAC: begin
            mul_a = s1_zero_ff ? 32'sd0 : {{(32 - SAMPLE_W){hist_q[SAMPLE_W-1]}}, hist_q};
            mul_b = {{(32 - COEF_W){coef_q[COEF_W-1]}}, coef_q};
         end
         MUL_WR_XR: begin mul_a = {{15{wr[16]}}, wr}; mul_b = xr; end
         MUL_WI_XI: begin mul_a = {{15{wi[16]}}, wi}; mul_b = xi; end
         MUL_WR_XI: begin mul_a = {{15{wr[16]}}, wr}; mul_b = xi; end
         MUL_WI_XR: begin mul_a = {{15{wi[16]}}, wi}; mul_b = xr; end
         MUL_RE_RE: begin mul_a = rd_a_q[63:32]; mul_b = rd_a_q[63:32]; end
         MUL_IM_IM: begin mul_a = rd_a_q[31:0]; mul_b = rd_a_q[31:0]; end
         default:   begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // polyphase accumulate; the last tap of a phase lands in bit-reversed order
   assign acc_in  = (s2_first_ff ? '0 : acc_ff) + prod_ff[ACC_W-1:0];
   assign acc_rnd = (acc_in + ACC_W'(65536)) >>> 17;
   assign mac_sum = sat32({{(64 - ACC_W){acc_rnd[ACC_W-1]}}, acc_rnd});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         head_ff     <= '0;
         fill_ff     <= '0;
      end else begin
         s1_valid_ff <= cmd.mac_issue;
         s2_valid_ff <= s1_valid_ff;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_zero_ff  <= age_zero;
      s1_last_ff  <= cmd.mac_last;
      s1_first_ff <= (cmd.k == '0);
      s1_m_ff     <= cmd.m;
      s2_last_ff  <= s1_last_ff;
      s2_first_ff <= s1_first_ff;
      s2_m_ff     <= s1_m_ff;
      if (s2_valid_ff) acc_ff <= acc_in;
   end

   // twiddle product accumulate
   always_ff @(posedge clock) begin
      case (cmd.tw_op)
         TW_TR_LOAD: tr_ff <= prod_ff;
         TW_TR_SUB:  tr_ff <= tr_ff - prod_ff;
         TW_TI_LOAD: ti_ff <= prod_ff;
         TW_TI_ADD:  ti_ff <= ti_ff + prod_ff;
         default:    tr_ff <= tr_ff;
      endcase
   end

   assign trr = (tr_ff + 64'sd16384) >>> 15;
   assign tir = (ti_ff + 64'sd16384) >>> 15;

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_last_ff)
         fft_mem[bitrev(s2_m_ff)] <= {mac_sum, 32'd0};
      else if (cmd.wr_u)
         fft_mem[u_addr] <= {sat32(ur + trr), sat32(ui + tir)};
      else if (cmd.wr_v)
         fft_mem[v_addr] <= {sat32(ur - trr), sat32(ui - tir)};
      if (cmd.bf_read || cmd.mg_read) rd_a_q <= fft_mem[rd_a_addr];
      if (cmd.bf_read) rd_b_q <= fft_mem[v_addr];
   end

   // digit-by-digit square root, two radicand bits per step
   assign rem_t = {rem_ff[REM_W-3:0], sq_ff[63:62]};
   assign trial = REM_W'({root_ff, 2'b01});
   assign ge    = (rem_t >= trial);

   always_ff @(posedge clock) begin
      case (cmd.sq_op)
         SQ_LOAD: sq_ff <= prod_ff;
         SQ_ADD: begin
            sq_ff   <= sq_ff + prod_ff;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         SQ_STEP: begin
            sq_ff   <= {sq_ff[61:0], 2'b00};
            rem_ff  <= ge ? rem_t - trial : rem_t;
            root_ff <= {root_ff[30:0], ge};
         end
         default: sq_ff <= sq_ff;
      endcase
   end

   // result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         band_ff <= BAND_W'(cmd.m);
         mag_ff  <= (root_ff[31:MAG_W] != '0) ? {MAG_W{1'b1}} : root_ff[MAG_W-1:0];
         last_ff <= (cmd.m == LOG_BANDS'(BANDS - 1));
      end
   end

   assign status.mac_busy = s1_valid_ff || s2_valid_ff;
   assign status.rsp_busy = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_band        = band_ff;
   assign rsp_magnitude   = mag_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== src/polyphase_fft_subband_analyzer.sv =====
// Top level of the polyphase FFT subband analyzer: stream ports, controller and datapath.
// Depends on pfsa_pkg, pfsa_ctrl and pfsa_dp.
//
//   channel   direction  carries
//   req_      in         coefficient load, sample or history clear
//   rsp_      out        one magnitude per band, tlast on the final band
//
// A load, clear or sample is taken while the block is idle. Every BANDS-th sample
// runs the block: the MAC over FILTER_LENGTH taps on one multiplier, then
// BANDS/2*log2(BANDS) butterflies, then for each band the squares and a 32-step
// square root. req_tready is low meanwhile.
// Reset clears the history fill count, block position and result valid; coefficients
// are undefined until loaded. A stalled result holds the sequencer, so the next band waits.
module polyphase_fft_subband_analyzer
   import pfsa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // coef_index[7:0], coef_value[25:8], sample[41:26]
   input  logic [FUNC_W-1:0]      req_tuser,  // func[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // band[4:0], magnitude[28:5]
   output logic                   rsp_tlast
);

   cmd_type              cmd;
   status_type           status;
   logic [BAND_W-1:0]    band;
   logic [MAG_W-1:0]     magnitude;

   pfsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pfsa_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .coef_index    (req_tdata[7:0]),
      .coef_value    (req_tdata[25:8]),
      .sample        (req_tdata[41:26]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_band      (band),
      .rsp_magnitude (magnitude),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, magnitude, band};

endmodule
